@@ src/msp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

    localparam int unsigned HEADER_BYTES = 8;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    localparam logic [7:0] SEC_FUNCTION = 8'd3;
    localparam logic [7:0] SEC_EXPORT   = 8'd7;

    localparam int unsigned LEB_MAX_GROUPS = 5;
    localparam int unsigned LEB_CONT_BIT   = 7;

    typedef enum logic [3:0] {
        PH_HEADER     = 4'd0,
        PH_SEC_ID     = 4'd1,
        PH_SEC_SIZE   = 4'd2,
        PH_SKIP       = 4'd3,
        PH_COUNT      = 4'd4,
        PH_NAME_LEN   = 4'd5,
        PH_NAME       = 4'd6,
        PH_KIND       = 4'd7,
        PH_EXP_INDEX  = 4'd8,
        PH_FUNC_INDEX = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        REC_SECTION = 2'd0,
        REC_EXPORT  = 2'd1,
        REC_FUNC    = 2'd2,
        REC_TRUNC   = 2'd3
    } t_rec_kind;

    typedef struct packed {
        t_rec_kind   kind;
        logic [7:0]  section_code;
        logic [31:0] start_offset;
        logic [31:0] byte_length;
        logic [7:0]  export_kind;
        logic [31:0] item_index;
        logic [31:0] entry_number;
    } t_rec;

    // records caused by one byte: an ordinary record, then a truncation record
    typedef struct packed {
        logic main_v;
        t_rec main;
        logic trunc_v;
        t_rec trunc;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

@@ src/module_section_stream_parser.sv @@
// Module section stream parser.
// Input channel: one byte of a module image per item (i_data_byte), with
// i_final_byte marking the last byte. An item is taken when push is high and
// full is low; a new byte may be offered in every cycle.
// Result channel: records (section, export, function type, truncated stream)
// leave through a queue interface: while empty is low the oldest record is on
// the o_ ports, and pop takes it.
// A record caused by a taken byte is first written into the queue, then
// registered into the output stage, and so shown on the o_ ports. Throughput:
// one byte per cycle in while full is low, one record per cycle out while pop
// stays high; a final byte that also ends a record yields two records, shown one after the other.
// A four-entry queue of per-byte record groups sits between the byte parser
// and the output stage; when pop stays low the queue fills and full rises,
// and bytes already taken are never lost.
// Reset clears the parser to the header phase and drops all queued records.
// After a final byte the parser returns to its reset state by itself.
`timescale 1ns / 1ps
`default_nettype none

module module_section_stream_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_final_byte,
    output logic        empty,
    input  wire         pop,
    output logic [1:0]  o_record_kind,
    output logic [7:0]  o_section_code,
    output logic [31:0] o_start_offset,
    output logic [31:0] o_byte_length,
    output logic [7:0]  o_export_kind,
    output logic [31:0] o_item_index,
    output logic [31:0] o_entry_number
);
    import msp_pkg::*;

    logic    w_take;
    logic    w_bundle_v;
    t_bundle w_bundle;
    t_bundle w_head;
    t_q_stat w_q_stat;
    logic    w_q_rd;
    t_rec    w_rec;

    assign full   = w_q_stat.full;
    assign w_take = push && !w_q_stat.full;

    msp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_bundle_v   (w_bundle_v),
        .o_bundle     (w_bundle)
    );

    msp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_bundle_v),
        .i_wdata (w_bundle),
        .i_rd    (w_q_rd),
        .o_rdata (w_head),
        .o_stat  (w_q_stat)
    );

    msp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (w_head),
        .i_q_stat (w_q_stat),
        .o_q_rd   (w_q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_rec    (w_rec)
    );

    assign o_record_kind  = w_rec.kind;
    assign o_section_code = w_rec.section_code;
    assign o_start_offset = w_rec.start_offset;
    assign o_byte_length  = w_rec.byte_length;
    assign o_export_kind  = w_rec.export_kind;
    assign o_item_index   = w_rec.item_index;
    assign o_entry_number = w_rec.entry_number;

endmodule

`default_nettype wire

@@ src/msp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msp_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_take,
    input  wire [7:0]        i_data_byte,
    input  wire              i_final_byte,
    output logic             o_bundle_v,
    output msp_pkg::t_bundle o_bundle
);
    import msp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_leb_value, n_leb_value;
    logic [2:0]  r_leb_shift, n_leb_shift;
    logic [7:0]  r_sec, n_sec;
    logic [31:0] r_sec_end, n_sec_end;
    logic [31:0] r_left, n_left;
    logic [31:0] r_ord, n_ord;
    logic [31:0] r_name_start, n_name_start;
    logic [31:0] r_name_len, n_name_len;
    logic [31:0] r_name_left, n_name_left;
    logic [7:0]  r_kind, n_kind;

    t_phase      w_ph;
    logic [31:0] w_nxt;
    logic [31:0] w_piece;
    logic [31:0] w_leb_val;
    logic [2:0]  w_shift_inc;
    logic        w_leb_done;
    t_phase      w_end_phase;
    logic [7:0]  w_end_sec;
    logic [31:0] w_end_ord;
    logic        w_clean;

    assign w_nxt      = r_pos + 32'd1;
    assign w_leb_done = ~i_data_byte[LEB_CONT_BIT];
    assign w_ph       = (r_phase == PH_HEADER && r_pos >= 32'(HEADER_BYTES)) ?
                        PH_SEC_ID : r_phase;

    // place the low seven bits of the byte at the current group (only the low four bits in the fifth group)
    always_comb begin
        case (r_leb_shift)
            3'd0:    w_piece = {25'd0, i_data_byte[6:0]};
            3'd1:    w_piece = {18'd0, i_data_byte[6:0], 7'd0};
            3'd2:    w_piece = {11'd0, i_data_byte[6:0], 14'd0};
            3'd3:    w_piece = {4'd0, i_data_byte[6:0], 21'd0};
            3'd4:    w_piece = {i_data_byte[3:0], 28'd0};
            default: w_piece = 32'd0;
        endcase
    end

    assign w_leb_val   = r_leb_value | w_piece;
    assign w_shift_inc = (r_leb_shift < 3'(LEB_MAX_GROUPS)) ? r_leb_shift + 3'd1 : r_leb_shift;

    // next state
    always_comb begin
        n_phase      = w_ph;
        n_pos        = w_nxt;
        n_leb_value  = r_leb_value;
        n_leb_shift  = r_leb_shift;
        n_sec        = r_sec;
        n_sec_end    = r_sec_end;
        n_left       = r_left;
        n_ord        = r_ord;
        n_name_start = r_name_start;
        n_name_len   = r_name_len;
        n_name_left  = r_name_left;
        n_kind       = r_kind;

        if (w_ph == PH_SEC_SIZE || w_ph == PH_COUNT || w_ph == PH_NAME_LEN ||
            w_ph == PH_EXP_INDEX || w_ph == PH_FUNC_INDEX) begin
            if (w_leb_done) begin
                n_leb_value = 32'd0;
                n_leb_shift = 3'd0;
            end else begin
                n_leb_value = w_leb_val;
                n_leb_shift = w_shift_inc;
            end
        end

        case (w_ph)
            PH_SEC_ID: begin
                n_sec       = i_data_byte;
                n_ord       = 32'd0;
                n_leb_value = 32'd0;
                n_leb_shift = 3'd0;
                n_phase     = PH_SEC_SIZE;
            end
            PH_SEC_SIZE: begin
                if (w_leb_done) begin
                    n_sec_end = w_nxt + w_leb_val;
                    if (w_leb_val == 32'd0) begin
                        n_phase = PH_SEC_ID;
                    end else if (r_sec == SEC_EXPORT || r_sec == SEC_FUNCTION) begin
                        n_phase = PH_COUNT;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_COUNT: begin
                if (w_leb_done) begin
                    n_left = w_leb_val;
                    n_ord  = 32'd0;
                    if (w_leb_val == 32'd0) begin
                        n_phase = PH_SKIP;
                    end else if (r_sec == SEC_EXPORT) begin
                        n_phase = PH_NAME_LEN;
                    end else begin
                        n_phase = PH_FUNC_INDEX;
                    end
                end
            end
            PH_NAME_LEN: begin
                if (w_leb_done) begin
                    n_name_start = w_nxt;
                    n_name_len   = w_leb_val;
                    n_name_left  = w_leb_val;
                    n_phase      = (w_leb_val != 32'd0) ? PH_NAME : PH_KIND;
                end
            end
            PH_NAME: begin
                n_name_left = r_name_left - 32'd1;
                if (r_name_left == 32'd1) begin
                    n_phase = PH_KIND;
                end
            end
            PH_KIND: begin
                n_kind  = i_data_byte;
                n_phase = PH_EXP_INDEX;
            end
            PH_EXP_INDEX, PH_FUNC_INDEX: begin
                if (w_leb_done) begin
                    n_ord  = r_ord + 32'd1;
                    n_left = r_left - 32'd1;
                    if (r_left == 32'd1) begin
                        n_phase = PH_SKIP;
                    end else if (w_ph == PH_EXP_INDEX) begin
                        n_phase = PH_NAME_LEN;
                    end
                end
            end
            default: begin
            end
        endcase

        // leave the section once the payload end is reached
        if (n_phase >= PH_SKIP && w_nxt == n_sec_end) begin
            n_phase     = PH_SEC_ID;
            n_leb_value = 32'd0;
            n_leb_shift = 3'd0;
        end

        w_end_phase = n_phase;
        w_end_sec   = n_sec;
        w_end_ord   = n_ord;

        // the final byte returns everything to the reset values
        if (i_final_byte) begin
            n_phase      = PH_HEADER;
            n_pos        = 32'd0;
            n_leb_value  = 32'd0;
            n_leb_shift  = 3'd0;
            n_sec        = 8'd0;
            n_sec_end    = 32'd0;
            n_left       = 32'd0;
            n_ord        = 32'd0;
            n_name_start = 32'd0;
            n_name_len   = 32'd0;
            n_name_left  = 32'd0;
            n_kind       = 8'd0;
        end
    end

    assign w_clean = (w_end_phase == PH_SEC_ID) ||
                     (w_end_phase == PH_HEADER && w_nxt >= 32'(HEADER_BYTES));

    // records
    always_comb begin
        o_bundle = '0;

        o_bundle.main.section_code = r_sec;
        o_bundle.main.item_index   = w_leb_val;
        case (w_ph)
            PH_SEC_SIZE: begin
                o_bundle.main_v            = w_leb_done;
                o_bundle.main.kind         = REC_SECTION;
                o_bundle.main.start_offset = w_nxt;
                o_bundle.main.byte_length  = w_leb_val;
                o_bundle.main.item_index   = 32'd0;
            end
            PH_EXP_INDEX: begin
                o_bundle.main_v            = w_leb_done;
                o_bundle.main.kind         = REC_EXPORT;
                o_bundle.main.start_offset = r_name_start;
                o_bundle.main.byte_length  = r_name_len;
                o_bundle.main.export_kind  = r_kind;
                o_bundle.main.entry_number = r_ord;
            end
            PH_FUNC_INDEX: begin
                o_bundle.main_v            = w_leb_done;
                o_bundle.main.kind         = REC_FUNC;
                o_bundle.main.entry_number = r_ord;
            end
            default: begin
                o_bundle.main_v = 1'b0;
            end
        endcase

        o_bundle.trunc_v            = i_final_byte && !w_clean;
        o_bundle.trunc.kind         = REC_TRUNC;
        o_bundle.trunc.section_code = (w_end_phase == PH_HEADER) ? 8'd0 : w_end_sec;
        o_bundle.trunc.start_offset = w_nxt;
        o_bundle.trunc.entry_number = w_end_ord;
    end

    assign o_bundle_v = i_take && (o_bundle.main_v || o_bundle.trunc_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pos        <= 32'd0;
            r_leb_value  <= 32'd0;
            r_leb_shift  <= 3'd0;
            r_sec        <= 8'd0;
            r_sec_end    <= 32'd0;
            r_left       <= 32'd0;
            r_ord        <= 32'd0;
            r_name_start <= 32'd0;
            r_name_len   <= 32'd0;
            r_name_left  <= 32'd0;
            r_kind       <= 8'd0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_leb_value  <= n_leb_value;
            r_leb_shift  <= n_leb_shift;
            r_sec        <= n_sec;
            r_sec_end    <= n_sec_end;
            r_left       <= n_left;
            r_ord        <= n_ord;
            r_name_start <= n_name_start;
            r_name_len   <= n_name_len;
            r_name_left  <= n_name_left;
            r_kind       <= n_kind;
        end
    end

`ifndef ASSERT_OFF
    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_pos <= 32'(HEADER_BYTES))
        else $error("header phase past header end");

    a_leb_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leb_shift <= 3'(LEB_MAX_GROUPS))
        else $error("leb group count out of range");

    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_final_byte |=> r_pos == 32'd0 && r_phase == PH_HEADER)
        else $error("state not cleared after final byte");
`endif

endmodule

`default_nettype wire

@@ src/msp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msp_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_wr,
    input  msp_pkg::t_bundle i_wdata,
    input  wire              i_rd,
    output msp_pkg::t_bundle o_rdata,
    output msp_pkg::t_q_stat o_stat
);
    import msp_pkg::*;

    t_bundle        r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_wr         = i_wr && !o_stat.full;
    assign w_rd         = i_rd && !o_stat.empty;
    assign o_rdata      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + QAW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + (QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_stat.full))
        else $error("write into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

@@ src/msp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msp_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  msp_pkg::t_bundle i_bundle,
    input  msp_pkg::t_q_stat i_q_stat,
    output logic             o_q_rd,
    input  wire              i_pop,
    output logic             o_empty,
    output msp_pkg::t_rec    o_rec
);
    import msp_pkg::*;

    t_rec r_cur;
    t_rec r_nxt;
    logic r_cur_v;
    logic r_nxt_v;
    logic w_adv;

    // the output slot frees when it is empty or being taken
    assign w_adv   = !r_cur_v || i_pop;
    assign o_q_rd  = w_adv && !r_nxt_v && !i_q_stat.empty;
    assign o_empty = !r_cur_v;
    assign o_rec   = r_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
            r_nxt_v <= 1'b0;
        end else if (w_adv) begin
            if (r_nxt_v) begin
                r_cur_v <= 1'b1;
                r_nxt_v <= 1'b0;
            end else if (!i_q_stat.empty) begin
                r_cur_v <= 1'b1;
                r_nxt_v <= i_bundle.main_v && i_bundle.trunc_v;
            end else begin
                r_cur_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_nxt_v) begin
                r_cur <= r_nxt;
            end else if (!i_q_stat.empty) begin
                r_cur <= i_bundle.main_v ? i_bundle.main : i_bundle.trunc;
                r_nxt <= i_bundle.trunc;
            end
        end
    end

`ifndef ASSERT_OFF
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nxt_v |-> r_cur_v)
        else $error("held second record without a shown record");
`endif

endmodule

`default_nettype wire
